// ===== src/hq_pkg.sv =====
// Shared types and codes for the hierarchical queue unit.
package hq_pkg;

	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP  = 2'd1;

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

	localparam int GroupWidth = 16;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  level;
		logic [19:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [19:0] popped_cell;
		logic [1:0]  status;
		logic [8:0]  level_count;
		logic        level_is_empty;
		logic        all_empty;
	} res_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        lvl_ok;
		logic [7:0]  level;
		logic [19:0] cell_idx;
	} op_t;

	typedef struct packed {
		logic avail;
		logic take;
	} qctl_t;

endpackage

// ===== src/hq_front.sv =====
// Front end: accepts words, classifies them and holds them in a two-entry queue.
module hq_front #(
	parameter int LEVELS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  hq_pkg::req_t  req,
	input  logic          take,
	output hq_pkg::qctl_t ctl,
	output hq_pkg::op_t   op
);

	hq_pkg::op_t ent_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	hq_pkg::op_t cls;
	logic        push;
	logic        pop;

	always_comb begin
		cls.level    = req.level;
		cls.cell_idx = req.cell_index;
		cls.lvl_ok   = (32'(req.level) < LEVELS);
		unique case (req.func)
			hq_pkg::FUNC_PUSH: cls.kind = hq_pkg::OP_PUSH;
			hq_pkg::FUNC_POP:  cls.kind = hq_pkg::OP_POP;
			default:           cls.kind = hq_pkg::OP_QUERY;
		endcase
	end

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign ctl.avail = (cnt_q != 2'd0);
	assign ctl.take  = take && ctl.avail;
	assign pop       = ctl.take;
	assign op        = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== src/hq_back.sv =====
// Back end: runs queue operations on the linked-list stores and forms results.
module hq_back #(
	parameter int LEVELS    = 256,
	parameter int CAPACITY  = 4096,
	parameter int CELL_BITS = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hq_pkg::qctl_t ctl,
	input  hq_pkg::op_t   op,
	output logic          take,
	output logic          done,
	output hq_pkg::res_t  res
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int NW  = $clog2(CAPACITY + 1);
	localparam int CW  = $clog2(LEVELS + 1);
	localparam int GW  = hq_pkg::GroupWidth;
	localparam int NG  = (LEVELS + GW - 1) / GW;
	localparam int GB  = (NG > 1) ? $clog2(NG) : 1;
	localparam int BB  = $clog2(GW);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_B    = 3'd2;
	localparam logic [2:0] S_C    = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [CELL_BITS-1:0] cell_mem [CAPACITY];
	logic [AW-1:0]        link_mem [CAPACITY];
	logic [AW-1:0]        head_mem [LEVELS];
	logic [AW-1:0]        tail_mem [LEVELS];

	logic [2:0]           state_q;
	hq_pkg::op_t          op_q;
	logic [LEVELS-1:0]    nonempty_q;
	logic [AW-1:0]        free_head_q;
	logic [NW-1:0]        free_cnt_q;
	logic [NW-1:0]        wm_q;
	logic [AW-1:0]        hd_rd_q;
	logic [AW-1:0]        tl_rd_q;
	logic [AW-1:0]        lk_rd_q;
	logic [CELL_BITS-1:0] cl_rd_q;
	logic [AW-1:0]        slot_q;
	logic [1:0]           status_q;
	logic                 pop_ok_q;
	logic                 done_q;
	hq_pkg::res_t         res_q;

	logic [LW-1:0]        idx;
	logic [AW-1:0]        lk_addr;
	logic                 lk_we;
	logic [AW-1:0]        lk_waddr;
	logic [AW-1:0]        lk_wdata;
	logic                 push_go;
	logic                 pop_go;
	logic [AW-1:0]        free_next;
	logic [NG*GW-1:0]     pad;
	logic [NG-1:0]        grp;
	logic [GB-1:0]        tg;
	logic [BB-1:0]        tb;
	logic                 any;
	logic [GW-1:0]        word;
	logic [CW-1:0]        count;
	logic [31:0]          cell32;
	logic [31:0]          count32;

	assign idx     = LW'(op_q.level);
	assign take    = (state_q == S_IDLE);
	assign push_go = (op_q.kind == hq_pkg::OP_PUSH) && op_q.lvl_ok && (free_cnt_q != '0);
	assign pop_go  = (op_q.kind == hq_pkg::OP_POP) && op_q.lvl_ok && nonempty_q[idx];
	assign lk_addr = (state_q == S_B) ? hd_rd_q : free_head_q;

	always_comb begin
		if (NW'(free_head_q) == wm_q) begin
			free_next = (32'(free_head_q) == CAPACITY - 1) ? '0 : free_head_q + 1'b1;
		end else begin
			free_next = lk_rd_q;
		end
	end

	always_comb begin
		lk_we    = 1'b0;
		lk_waddr = tl_rd_q;
		lk_wdata = free_head_q;
		if (state_q == S_B && push_go && nonempty_q[idx]) begin
			lk_we = 1'b1;
		end else if (state_q == S_C) begin
			lk_we    = 1'b1;
			lk_waddr = slot_q;
		end
	end

	always_ff @(posedge clk) begin
		lk_rd_q <= link_mem[lk_addr];
		if (lk_we) link_mem[lk_waddr] <= (state_q == S_C) ? lk_wdata : free_head_q;
	end

	always_ff @(posedge clk) begin
		cl_rd_q <= cell_mem[hd_rd_q];
		if (state_q == S_B && push_go) cell_mem[free_head_q] <= CELL_BITS'(op_q.cell_idx);
	end

	always_ff @(posedge clk) begin
		hd_rd_q <= head_mem[idx];
		tl_rd_q <= tail_mem[idx];
		if (state_q == S_B && push_go) begin
			tail_mem[idx] <= free_head_q;
			if (!nonempty_q[idx]) head_mem[idx] <= free_head_q;
		end else if (state_q == S_C && slot_q != tl_rd_q) begin
			head_mem[idx] <= lk_rd_q;
		end
	end

	always_comb begin
		pad = (NG*GW)'(nonempty_q);
		tg  = '0;
		any = 1'b0;
		for (int g = 0; g < NG; g++) begin
			grp[g] = |pad[g*GW +: GW];
			if (grp[g]) begin
				tg  = GB'(g);
				any = 1'b1;
			end
		end
		word = pad[tg*GW +: GW];
		tb   = '0;
		for (int b = 0; b < GW; b++) begin
			if (word[b]) tb = BB'(b);
		end
		count = any ? CW'(32'(tg) * GW + 32'(tb) + 1) : '0;
	end

	assign cell32  = 32'(cl_rd_q);
	assign count32 = 32'(count);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && ctl.take) op_q <= op;
		if (state_q == S_B) begin
			slot_q   <= hd_rd_q;
			pop_ok_q <= pop_go;
			if (op_q.kind == hq_pkg::OP_PUSH && !push_go) status_q <= hq_pkg::ST_PUSH_FULL;
			else if (op_q.kind == hq_pkg::OP_POP && !pop_go) status_q <= hq_pkg::ST_POP_EMPTY;
			else status_q <= hq_pkg::ST_OK;
		end
		if (state_q == S_OUT) begin
			res_q.popped_cell    <= pop_ok_q ? cell32[19:0] : '0;
			res_q.status         <= status_q;
			res_q.level_count    <= count32[8:0];
			res_q.level_is_empty <= !op_q.lvl_ok || !nonempty_q[idx];
			res_q.all_empty      <= !any;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nonempty_q  <= '0;
			free_head_q <= '0;
			free_cnt_q  <= NW'(CAPACITY);
			wm_q        <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (state_q == S_OUT);
			unique case (state_q)
				S_IDLE: if (ctl.take) state_q <= S_RD;
				S_RD:   state_q <= S_B;
				S_B: begin
					if (push_go) begin
						nonempty_q[idx] <= 1'b1;
						free_head_q     <= free_next;
						free_cnt_q      <= free_cnt_q - 1'b1;
						if (NW'(free_head_q) == wm_q) wm_q <= wm_q + 1'b1;
					end
					state_q <= pop_go ? S_C : S_OUT;
				end
				S_C: begin
					if (slot_q == tl_rd_q) nonempty_q[idx] <= 1'b0;
					free_head_q <= slot_q;
					free_cnt_q  <= free_cnt_q + 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== src/hierarchical_queue_unit.sv =====
// Top level of the hierarchical queue unit.
// A push or query result strobes after the back end's S_RD, S_B and S_OUT states; a pop
// also passes S_C. The back end takes no new word until the last has left S_OUT, given
// its sequence of synchronous reads of the head, tail, link and cell memories.
// A two-entry queue absorbs words while the back end works; the receiver cannot stall.
// Reset clears the level map and free list state at once; no clearing pass is needed.
module hierarchical_queue_unit #(
	parameter int LEVELS    = 256,
	parameter int CAPACITY  = 4096,
	parameter int CELL_BITS = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  hq_pkg::req_t req,
	output logic         done,
	output hq_pkg::res_t res
);

	hq_pkg::qctl_t ctl;
	hq_pkg::op_t   op;
	logic          take;

	hq_front #(.LEVELS(LEVELS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.take   (take),
		.ctl    (ctl),
		.op     (op)
	);

	hq_back #(
		.LEVELS    (LEVELS),
		.CAPACITY  (CAPACITY),
		.CELL_BITS (CELL_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.op     (op),
		.take   (take),
		.done   (done),
		.res    (res)
	);

	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("results strobed back to back");

	a_empty_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status == hq_pkg::ST_POP_EMPTY |-> res.popped_cell == '0)
		else $error("failed pop returned a cell");

	a_all_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.all_empty == (res.level_count == '0)))
		else $error("all_empty disagrees with level_count");

endmodule
